// ===== rtl/ptb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// Field widths, register indexes, record codes and the sequencer states.
// ----------------------------------------------------------------------------
package ptb_pkg;

   // Programmable timers in the bank
   localparam int NUM_TIMERS  = 10;
   localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Field widths
   localparam int TIME_W      = 32;
   localparam int TICK_INC_W  = 10;
   localparam int ID_W        = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_INC     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RTX_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RTX_ENABLE   = 2'd3;

   // Register reset values
   localparam logic [TICK_INC_W-1:0] TICK_INC_RST     = 10'd26;
   localparam logic [TIME_W-1:0]     MIN_INTERVAL_RST = 32'd50;
   localparam logic [TIME_W-1:0]     RTX_INTERVAL_RST = 32'd26;
   localparam logic                  RTX_ENABLE_RST   = 1'b1;

   // Request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // Response record kinds
   localparam logic REC_FIRE    = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   // Identifier reported for the retransmission timer
   localparam logic [ID_W-1:0] RETRANS_ID = 4'd10;
   localparam logic [ID_W-1:0] SUMMARY_ID = 4'd0;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RTX,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/ptb_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_channels: request and response channels of the periodic timer bank
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Request channel: tick or timer set
interface ptb_req_if import ptb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [ID_W-1:0]        timer_index;
   logic                   enable;
   logic [TIME_W-1:0]      last_time;
   logic [TIME_W-1:0]      interval;

   modport source (
      output valid, kind, timer_index, enable, last_time, interval,
      input  ready
   );
   modport sink (
      input  valid, kind, timer_index, enable, last_time, interval,
      output ready
   );
endinterface

// Response channel: fire records and the end-of-tick summary
interface ptb_rsp_if import ptb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   record_kind;
   logic [ID_W-1:0]        fired_id;
   logic [TIME_W-1:0]      now_ms;
   logic [TIME_W-1:0]      seq_count;
   logic                   last;

   modport source (
      output valid, record_kind, fired_id, now_ms, seq_count, last,
      input  ready
   );
   modport sink (
      input  valid, record_kind, fired_id, now_ms, seq_count, last,
      output ready
   );
endinterface

// ===== rtl/periodic_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit: bank of periodic timers driven by a system tick
//
//   channel   dir  handshake               word
//   req_chan  in   valid/ready             kind, timer_index, enable,
//                                          last_time, interval
//   rsp_chan  out  valid/ready             record_kind, fired_id, now_ms,
//                                          seq_count, last
//   csr_*     in   csr_we (no back-press)  csr_index, csr_wdata
//
// A set word is written into the bank when accepted. A tick word runs in
// order: accept, retransmission check, one programmable timer per cycle
// through the single shared add/compare unit, then the summary. A check
// that fires, or the summary, waits while the response register is full and
// not being drained. Reset (synchronous, active high) restores the register
// defaults, clears time, counter and all armed bits, and empties the output.
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit import ptb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ptb_req_if.sink               req_chan,
   ptb_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [TICK_INC_W-1:0] tick_inc_ff;
   logic [TIME_W-1:0]     min_interval_ff;
   logic [TIME_W-1:0]     rtx_interval_ff;
   logic                  rtx_enable_ff;

   // Timer state
   logic [TIME_W-1:0]     now_ff,  now_in;
   logic [TIME_W-1:0]     seq_ff,  seq_in;
   logic [TIME_W-1:0]     rtx_last_ff, rtx_last_in;
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [TIME_W-1:0]     timer_last_ff   [NUM_TIMERS];
   logic [TIME_W-1:0]     timer_period_ff [NUM_TIMERS];

   // Sequencer
   state_type             state_ff, state_in;
   logic [TIMER_IDX_W-1:0] idx_ff, idx_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [TIME_W-1:0]     rsp_now_ff;
   logic [TIME_W-1:0]     rsp_seq_ff;
   logic                  rsp_last_ff;

   // Shared unit operands and results
   logic [TIME_W-1:0]     op_last;
   logic [TIME_W-1:0]     op_period;
   logic [TIME_W-1:0]     op_ref;
   logic [TIME_W-1:0]     op_sum;
   logic                  op_ge;
   logic                  op_armed;
   logic                  due;

   // Control
   logic                  req_accept;
   logic                  tick_accept;
   logic                  set_accept;
   logic                  set_in_range;
   logic                  slot_free;
   logic                  check_go;
   logic                  fire_load;
   logic                  summary_load;

   assign req_accept   = req_chan.valid && req_chan.ready;
   assign tick_accept  = req_accept && (req_chan.kind == KIND_TICK);
   assign set_accept   = req_accept && (req_chan.kind == KIND_SET);
   assign set_in_range = 32'(req_chan.timer_index) < NUM_TIMERS;
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_inc_ff     <= TICK_INC_RST;
         min_interval_ff <= MIN_INTERVAL_RST;
         rtx_interval_ff <= RTX_INTERVAL_RST;
         rtx_enable_ff   <= RTX_ENABLE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_INC:     tick_inc_ff     <= csr_wdata[TICK_INC_W-1:0];
            CSR_MIN_INTERVAL: min_interval_ff <= csr_wdata[TIME_W-1:0];
            CSR_RTX_INTERVAL: rtx_interval_ff <= csr_wdata[TIME_W-1:0];
            CSR_RTX_ENABLE:   rtx_enable_ff   <= csr_wdata[0];
         endcase
      end
   end

   // Select operands for the shared add/compare unit.
   // Idle: clamp compare, min_interval >= interval. Checks: now >= last + period.
   always_comb begin
      unique case (state_ff)
         ST_RTX: begin
            op_last   = rtx_last_ff;
            op_period = rtx_interval_ff;
            op_ref    = now_ff;
            op_armed  = rtx_enable_ff;
         end
         ST_SCAN: begin
            op_last   = timer_last_ff[idx_ff];
            op_period = timer_period_ff[idx_ff];
            op_ref    = now_ff;
            op_armed  = armed_ff[idx_ff];
         end
         default: begin
            op_last   = '0;
            op_period = req_chan.interval;
            op_ref    = min_interval_ff;
            op_armed  = 1'b0;
         end
      endcase
   end

   // Shared unit: one wrapping add and one unsigned compare
   assign op_sum = op_last + op_period;
   assign op_ge  = op_ref >= op_sum;
   assign due    = op_armed && op_ge;

   // Next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_accept) begin
               state_in = ST_RTX;
            end
         end
         ST_RTX: begin
            if (check_go) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (check_go) begin
               if (32'(idx_ff) == NUM_TIMERS - 1) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      check_go       = 1'b0;
      fire_load      = 1'b0;
      summary_load   = 1'b0;
      unique case (state_ff)
         ST_RTX, ST_SCAN: begin
            check_go  = !due || slot_free;
            fire_load = due && slot_free;
         end
         ST_DONE: begin
            summary_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Advance clock and counter on a tick; record the fire time of the
   // retransmission timer
   always_comb begin
      now_in      = now_ff;
      seq_in      = seq_ff;
      rtx_last_in = rtx_last_ff;
      if (tick_accept) begin
         now_in = now_ff + TIME_W'(tick_inc_ff);
         seq_in = seq_ff + 1'b1;
      end
      if (fire_load && (state_ff == ST_RTX)) begin
         rtx_last_in = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         now_ff      <= '0;
         seq_ff      <= '0;
         rtx_last_ff <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         now_ff      <= now_in;
         seq_ff      <= seq_in;
         rtx_last_ff <= rtx_last_in;
      end
   end

   // Armed bits: cleared by reset, loaded by a set word
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else if (set_accept && set_in_range) begin
         armed_ff[TIMER_IDX_W'(req_chan.timer_index)] <= req_chan.enable;
      end
   end

   // Timer last and period: an entry is read only once its armed bit is set,
   // and the set word writes all three together
   always_ff @(posedge clock) begin
      if (set_accept && set_in_range) begin
         timer_last_ff[TIMER_IDX_W'(req_chan.timer_index)]   <= req_chan.last_time;
         timer_period_ff[TIMER_IDX_W'(req_chan.timer_index)] <=
            op_ge ? min_interval_ff : req_chan.interval;
      end else if (fire_load && (state_ff == ST_SCAN)) begin
         timer_last_ff[idx_ff] <= now_ff;
      end
   end

   // Response register: load on fire or summary, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_load || summary_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_load) begin
         rsp_kind_ff <= REC_FIRE;
         rsp_id_ff   <= (state_ff == ST_RTX) ? RETRANS_ID : ID_W'(idx_ff);
         rsp_now_ff  <= now_ff;
         rsp_seq_ff  <= seq_ff;
         rsp_last_ff <= 1'b0;
      end else if (summary_load) begin
         rsp_kind_ff <= REC_SUMMARY;
         rsp_id_ff   <= SUMMARY_ID;
         rsp_now_ff  <= now_ff;
         rsp_seq_ff  <= seq_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.record_kind = rsp_kind_ff;
   assign rsp_chan.fired_id    = rsp_id_ff;
   assign rsp_chan.now_ms      = rsp_now_ff;
   assign rsp_chan.seq_count   = rsp_seq_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A tick word starts the scan with the retransmission check
   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> (state_ff == ST_RTX))
      else $error("tick word did not start the retransmission check");

   // A tick word advances the sequence counter by one
   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> (seq_ff == $past(seq_ff) + 1'b1))
      else $error("sequence counter did not advance on tick");

   // The scan index stays within the bank
   a_idx_in_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(idx_ff) < NUM_TIMERS))
      else $error("scan index beyond the timer bank");

   // A summary word is only loaded at the end of a scan
   a_summary_after_scan: assert property (@(posedge clock) disable iff (reset)
      summary_load |-> $past(state_ff == ST_SCAN || state_ff == ST_DONE))
      else $error("summary loaded without a completed scan");
`endif

endmodule

// ===== tb/sv/periodic_timer_bank_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit_tb: self-checking bench for the periodic timer bank
// Feeds tick and set words through the request channel under random gaps and
// back-pressure. A cycle-free model of the bank predicts the fire and summary
// words. Each response word is checked against the oldest prediction. The
// run walks through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit_tb;
   import ptb_pkg::*;

   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_AT       = 60;
   localparam int HOLD_LEN      = 300;
   localparam int PHASE_WORDS   = 27;

   typedef struct {
      logic              kind;
      logic [ID_W-1:0]   timer_index;
      logic              enable;
      logic [TIME_W-1:0] last_time;
      logic [TIME_W-1:0] interval;
   } req_word_type;

   typedef struct {
      logic              record_kind;
      logic [ID_W-1:0]   fired_id;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] seq_count;
      logic              last;
   } rsp_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ptb_req_if req_chan ();
   ptb_rsp_if rsp_chan ();

   periodic_timer_bank_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Bank model: registers and timer state
   logic [TICK_INC_W-1:0] tick_inc_m;
   logic [TIME_W-1:0]     min_iv_m;
   logic [TIME_W-1:0]     rtx_iv_m;
   logic                  rtx_en_m;
   logic [TIME_W-1:0]     clock_ms_m;
   logic [TIME_W-1:0]     seq_m;
   logic [TIME_W-1:0]     rtx_last_m;
   logic                  armed_m  [NUM_TIMERS];
   logic [TIME_W-1:0]     last_m   [NUM_TIMERS];
   logic [TIME_W-1:0]     period_m [NUM_TIMERS];

   req_word_type pending_words[$];
   rsp_word_type due_records[$];
   req_word_type cur_word;

   int send_wait;
   bit send_burst;
   int take_wait;
   bit take_burst;
   int hold_left;
   int records_taken;
   int fail_count;
   int idle_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Restore register defaults and clear the timer state
   function automatic void reset_bank_model();
      tick_inc_m = TICK_INC_RST;
      min_iv_m   = MIN_INTERVAL_RST;
      rtx_iv_m   = RTX_INTERVAL_RST;
      rtx_en_m   = RTX_ENABLE_RST;
      clock_ms_m = '0;
      seq_m      = '0;
      rtx_last_m = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         armed_m[i]  = 1'b0;
         last_m[i]   = '0;
         period_m[i] = '0;
      end
   endfunction

   function automatic void post_record(logic kind, logic [ID_W-1:0] id, logic fin);
      rsp_word_type r;
      r.record_kind = kind;
      r.fired_id    = id;
      r.now_ms      = clock_ms_m;
      r.seq_count   = seq_m;
      r.last        = fin;
      due_records.push_back(r);
   endfunction

   // Apply one accepted word to the model and queue the records it causes
   function automatic void run_bank_word(req_word_type w);
      logic [TIME_W-1:0] next_due;
      if (w.kind == KIND_SET) begin
         if (w.timer_index < NUM_TIMERS) begin
            armed_m[w.timer_index]  = w.enable;
            last_m[w.timer_index]   = w.last_time;
            period_m[w.timer_index] = (w.interval > min_iv_m) ? w.interval : min_iv_m;
         end
         return;
      end
      clock_ms_m = clock_ms_m + TIME_W'(tick_inc_m);
      seq_m      = seq_m + 1;
      // retransmission timer first, then the bank in index order
      if (rtx_en_m) begin
         next_due = rtx_last_m + rtx_iv_m;
         if (clock_ms_m >= next_due) begin
            rtx_last_m = clock_ms_m;
            post_record(REC_FIRE, RETRANS_ID, 1'b0);
         end
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
         next_due = last_m[i] + period_m[i];
         if (armed_m[i] && clock_ms_m >= next_due) begin
            last_m[i] = clock_ms_m;
            post_record(REC_FIRE, ID_W'(i), 1'b0);
         end
      end
      post_record(REC_SUMMARY, SUMMARY_ID, 1'b1);
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TICK_INC:     tick_inc_m = data[TICK_INC_W-1:0];
         CSR_MIN_INTERVAL: min_iv_m   = data;
         CSR_RTX_INTERVAL: rtx_iv_m   = data;
         CSR_RTX_ENABLE:   rtx_en_m   = data[0];
         default: ;
      endcase
   endfunction

   // Gap before the next word; flip between bursts and random gaps now and then
   function automatic int draw_gap(ref bit burst);
      if ($urandom_range(0, 15) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   // Driver: offer pending words, run the model on each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.kind        <= KIND_TICK;
         req_chan.timer_index <= '0;
         req_chan.enable      <= 1'b0;
         req_chan.last_time   <= '0;
         req_chan.interval    <= '0;
         send_wait = 0;
         reset_bank_model();
      end else begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (req_chan.valid && req_chan.ready) begin
            run_bank_word(cur_word);
            send_wait = draw_gap(send_burst);
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the offered word
         end else if (send_wait > 0) begin
            send_wait--;
            req_chan.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            cur_word = pending_words.pop_front();
            req_chan.kind        <= cur_word.kind;
            req_chan.timer_index <= cur_word.timer_index;
            req_chan.enable      <= cur_word.enable;
            req_chan.last_time   <= cur_word.last_time;
            req_chan.interval    <= cur_word.interval;
            req_chan.valid       <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each response word, then stall at random
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            records_taken++;
            if (due_records.size() == 0) begin
               $error("response word with no prediction pending");
               fail_count++;
            end else begin
               want = due_records.pop_front();
               if (rsp_chan.record_kind !== want.record_kind) begin
                  $error("record_kind: expected %0d, actual %0d",
                         want.record_kind, rsp_chan.record_kind);
                  fail_count++;
               end
               if (rsp_chan.fired_id !== want.fired_id) begin
                  $error("fired_id: expected %0d, actual %0d",
                         want.fired_id, rsp_chan.fired_id);
                  fail_count++;
               end
               if (rsp_chan.now_ms !== want.now_ms) begin
                  $error("now_ms: expected %0d, actual %0d", want.now_ms, rsp_chan.now_ms);
                  fail_count++;
               end
               if (rsp_chan.seq_count !== want.seq_count) begin
                  $error("seq_count: expected %0d, actual %0d",
                         want.seq_count, rsp_chan.seq_count);
                  fail_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_chan.last);
                  fail_count++;
               end
            end
            take_wait = draw_gap(take_burst);
            // long hold-off once, so the bank fills up and stalls its input
            if (records_taken == HOLD_AT) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Count cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Watchdog
   initial begin
      do @(posedge clock); while (idle_cycles < STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_word_type tick_word();
      req_word_type w;
      w.kind        = KIND_TICK;
      w.timer_index = ID_W'($urandom_range(0, 15));
      w.enable      = 1'($urandom_range(0, 1));
      w.last_time   = $urandom();
      w.interval    = $urandom();
      return w;
   endfunction

   function automatic req_word_type set_word(int idx, logic en, logic [TIME_W-1:0] lt,
                                             logic [TIME_W-1:0] iv);
      req_word_type w;
      w.kind        = KIND_SET;
      w.timer_index = ID_W'(idx);
      w.enable      = en;
      w.last_time   = lt;
      w.interval    = iv;
      return w;
   endfunction

   // Queue random words; armed timers start near the current time
   task automatic queue_phase(int count);
      req_word_type      w;
      logic [TIME_W-1:0] gen_now;
      int                step;
      int                pick;
      gen_now = clock_ms_m;
      step    = int'(tick_inc_m);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            w = tick_word();
            gen_now += step;
         end else if (pick < 80) begin
            w = set_word($urandom_range(0, NUM_TIMERS - 1), $urandom_range(0, 4) != 0,
                         gen_now - $urandom_range(0, 4 * step + 100),
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8 * step + 100));
         end else if (pick < 90) begin
            w = set_word($urandom_range(NUM_TIMERS, 15), 1'($urandom_range(0, 1)),
                         $urandom(), $urandom());
         end else begin
            w = set_word($urandom_range(0, 15), 1'($urandom_range(0, 1)),
                         $urandom(), $urandom());
         end
         pending_words.push_back(w);
      end
   endtask

   // Wait until every word is taken and every record is out, then settle;
   // look between edges so the driver's updates of the edge have landed
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || due_records.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on back-to-back edges
   task automatic write_config(logic [CSR_DATA_W-1:0] tick_inc, logic [CSR_DATA_W-1:0] min_iv,
                               logic [CSR_DATA_W-1:0] rtx_iv, logic [CSR_DATA_W-1:0] rtx_en);
      csr_we    <= 1'b1;
      csr_index <= CSR_TICK_INC;
      csr_wdata <= tick_inc;
      @(posedge clock);
      csr_index <= CSR_MIN_INTERVAL;
      csr_wdata <= min_iv;
      @(posedge clock);
      csr_index <= CSR_RTX_INTERVAL;
      csr_wdata <= rtx_iv;
      @(posedge clock);
      csr_index <= CSR_RTX_ENABLE;
      csr_wdata <= rtx_en;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Stimulus and end of run
   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_TICK;
      req_chan.timer_index = '0;
      req_chan.enable      = 1'b0;
      req_chan.last_time   = '0;
      req_chan.interval    = '0;
      rsp_chan.ready       = 1'b0;
      fail_count           = 0;
      records_taken        = 0;
      send_burst           = 1'b0;
      take_burst           = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the register defaults
      pending_words.push_back(tick_word());
      // zero interval raised to the minimum
      pending_words.push_back(set_word(0, 1'b1, 32'd0, 32'd0));
      // last + period wraps past zero
      pending_words.push_back(set_word(9, 1'b1, 32'hFFFF_FFF0, 32'd100));
      // indexes out of range are dropped
      pending_words.push_back(set_word(10, 1'b1, 32'd0, 32'd0));
      pending_words.push_back(set_word(15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // disarmed timer never fires
      pending_words.push_back(set_word(5, 1'b0, 32'd0, 32'd1));
      pending_words.push_back(set_word(3, 1'b1, 32'd0, 32'hFFFF_FFFF));
      pending_words.push_back(set_word(1, 1'b1, 32'd10, 32'd60));
      pending_words.push_back(set_word(2, 1'b1, 32'd0, 32'd49));
      pending_words.push_back(set_word(8, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      repeat (6) pending_words.push_back(tick_word());
      pending_words.push_back(set_word(0, 1'b0, 32'd0, 32'd0));
      pending_words.push_back(set_word(7, 1'b1, 32'h5555_AAAA, 32'hAAAA_5555));
      repeat (4) pending_words.push_back(tick_word());
      wait_drained();

      // Fastest clock, no minimum: every timer can fire on every tick
      write_config(32'd1, 32'd0, 32'd0, 32'd1);
      queue_phase(PHASE_WORDS);
      wait_drained();

      // Largest legal step, widest minimum, retransmission off
      write_config(32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      queue_phase(PHASE_WORDS);
      wait_drained();

      // Step written as zero through the upper bits, retransmission on
      write_config(32'h0000_0400, 32'd7, 32'd3, 32'hFFFF_FFFF);
      queue_phase(PHASE_WORDS);
      wait_drained();

      // Random setting with noise above the step field
      write_config({22'($urandom_range(0, 4194303)), 10'(0)} | $urandom_range(1, 1000),
                   $urandom_range(0, 300),
                   ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300),
                   $urandom());
      queue_phase(PHASE_WORDS);
      wait_drained();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
